// ----- rtl/smt_pkg.sv -----
// Shared types and constants for the streaming mode tracker.
package smt_pkg;

  localparam int KEY_BITS   = 10;
  localparam int COUNT_BITS = 16;
  localparam int KEY_DEPTH  = 1 << KEY_BITS;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // operation codes
  localparam logic OP_COUNT = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef struct packed {
    logic                operation;
    logic [KEY_BITS-1:0] event_key;
  } smt_req_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]   leader_key;
    logic [COUNT_BITS-1:0] leader_count;
  } smt_res_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic sweeping;
  } smt_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic pending_clear;
    logic sweep_last;
  } smt_status_t;

endpackage

// ----- rtl/smt_controller.sv -----
// Controller: sweep / run sequencing and input acceptance.
module smt_controller import smt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  smt_status_t status,
  output logic        busy,
  output smt_cmd_t    cmd
);

  typedef enum logic {
    ST_SWEEP,
    ST_RUN
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SWEEP;
    end else begin
      unique case (state)
        ST_SWEEP: begin
          if (status.sweep_last) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (status.pending_clear) begin
            state <= ST_SWEEP;
          end
        end
        default: state <= ST_SWEEP;
      endcase
    end
  end

  // a clear in flight blocks the next transaction until its sweep is done
  assign busy         = (state == ST_SWEEP) || status.pending_clear;
  assign cmd.accept   = start && !busy;
  assign cmd.sweeping = (state == ST_SWEEP);

endmodule

// ----- rtl/smt_datapath.sv -----
// Datapath: histogram store, count update with forwarding, leader registers.
module smt_datapath import smt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  smt_req_t    request,
  input  smt_cmd_t    cmd,
  output smt_status_t status,
  output logic        done,
  output smt_res_t    result
);

  logic [COUNT_BITS-1:0] mem [KEY_DEPTH];

  logic                  s1_valid;
  logic                  s1_op;
  logic [KEY_BITS-1:0]   s1_key;
  logic [COUNT_BITS-1:0] rd_data;
  logic                  fwd_hit;
  logic [COUNT_BITS-1:0] fwd_count;
  logic [KEY_BITS-1:0]   sweep_addr;
  logic [KEY_BITS-1:0]   best_key;
  logic [COUNT_BITS-1:0] best_count;

  logic                  s1_count;
  logic [COUNT_BITS-1:0] cur_count;
  logic [COUNT_BITS-1:0] new_count;
  logic                  wr_en;
  logic [KEY_BITS-1:0]   wr_addr;
  logic [COUNT_BITS-1:0] wr_data;

  always_comb begin
    s1_count  = s1_valid && (s1_op == OP_COUNT);
    // the previous transaction's write lands on the same edge as this read
    cur_count = fwd_hit ? fwd_count : rd_data;
    new_count = (cur_count == COUNT_MAX) ? cur_count : cur_count + COUNT_BITS'(1);
    wr_en     = cmd.sweeping || s1_count;
    wr_addr   = cmd.sweeping ? sweep_addr : s1_key;
    wr_data   = cmd.sweeping ? '0 : new_count;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.accept) begin
      rd_data <= mem[request.event_key];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      s1_op     <= request.operation;
      s1_key    <= request.event_key;
      fwd_hit   <= s1_count && (s1_key == request.event_key);
      fwd_count <= new_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      done       <= 1'b0;
      sweep_addr <= '0;
      best_key   <= '0;
      best_count <= '0;
    end else begin
      s1_valid <= cmd.accept;
      done     <= s1_valid;
      if (cmd.sweeping) begin
        sweep_addr <= sweep_addr + KEY_BITS'(1);
      end else begin
        sweep_addr <= '0;
      end
      if (s1_valid && (s1_op == OP_CLEAR)) begin
        best_key   <= '0;
        best_count <= '0;
      end else if (s1_count && (new_count > best_count)) begin
        best_key   <= s1_key;
        best_count <= new_count;
      end
    end
  end

  assign status.pending_clear = s1_valid && (s1_op == OP_CLEAR);
  assign status.sweep_last    = (sweep_addr == '1);

  assign result.leader_key   = best_key;
  assign result.leader_count = best_count;

endmodule

// ----- rtl/streaming_mode_tracker.sv -----
// Streaming mode tracker: histogram of event keys with first-to-max leader.
// An accepted transaction is registered in s1_valid, and its done strobe is registered from that.
// Throughput: one count transaction per cycle while busy is low; the store read-modify-write
//   takes two stages with forwarding from the write stage, so repeated keys need no stall.
// A clear holds busy through the clear stage, then through a one-entry-per-cycle zeroing
//   sweep of the store. Reset starts the same sweep with busy high.
// The receiver cannot stall: done is a one-cycle strobe and result is valid with it.
module streaming_mode_tracker import smt_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  smt_req_t request,
  output logic     done,
  output smt_res_t result
);

  smt_cmd_t    cmd;
  smt_status_t status;

  // Controller: sweeps the store after reset and after each clear, and
  // gates acceptance of new transactions while that happens.
  smt_controller u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .busy   (busy),
    .cmd    (cmd)
  );

  // Datapath: stage 0 reads the count on acceptance, stage 1 increments
  // (saturating), writes back, and updates the leader only on a strictly
  // greater count, so on a tie the earlier key keeps the lead.
  smt_datapath u_dp (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .cmd     (cmd),
    .status  (status),
    .done    (done),
    .result  (result)
  );

endmodule

// ----- rtl/smt_checker.sv -----
// Port-level checker for the streaming mode tracker, bound to the top level.
module smt_checker import smt_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     start,
  input logic     busy,
  input smt_req_t request,
  input logic     done,
  input smt_res_t result
);

  // the store sweep follows reset
  a_busy_after_reset: assert property (@(posedge clk) rst |=> busy)
    else $error("busy low straight after reset");

  // every accepted transaction is followed by its done strobe
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("missing result for accepted transaction");

  // a clear blocks input and reports an empty leader
  a_clear_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && request.operation == OP_CLEAR) |=> busy)
    else $error("input not blocked after clear");

  a_clear_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && request.operation == OP_CLEAR) |->
      ##2 (result.leader_count == '0 && result.leader_key == '0))
    else $error("clear did not empty the leader");

  // an empty histogram always reports key zero
  a_empty_key: assert property (@(posedge clk) disable iff (rst)
    (done && result.leader_count == '0) |-> (result.leader_key == '0))
    else $error("nonzero key with zero count");

endmodule

bind streaming_mode_tracker smt_checker u_smt_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .request (request),
  .done    (done),
  .result  (result)
);

// ----- verif/tb_streaming_mode_tracker.sv -----
// Self-checking testbench for the streaming mode tracker: histogram counts and leader key.
`timescale 1ns / 1ps

module tb_streaming_mode_tracker;
  import smt_pkg::*;

  // Generous ceiling: each clear holds busy through a sweep of the whole store, yet
  // even a run made of nothing but clears stays well inside it.
  localparam int CYCLE_LIMIT  = 4_000_000;
  localparam int REPORT_FIRST = 10;
  localparam int HOT_RUN      = 10;

  logic     clk     = 1'b0;
  logic     rst     = 1'b1;
  logic     start   = 1'b0;
  smt_req_t request = '0;
  logic     busy;
  logic     done;
  smt_res_t result;

  streaming_mode_tracker u_dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Leader prediction: own copy of the histogram and of the current leader.
  // ---------------------------------------------------------------------------
  logic [COUNT_BITS-1:0] key_tally [KEY_DEPTH];
  logic [KEY_BITS-1:0]   lead_key   = '0;
  logic [COUNT_BITS-1:0] lead_count = '0;

  initial foreach (key_tally[i]) key_tally[i] = '0;

  // Applies one transaction to the histogram and returns the leader it leaves.
  function automatic smt_res_t tally_event(smt_req_t req);
    smt_res_t              leader;
    logic [COUNT_BITS-1:0] cnt;
    if (req.operation == OP_CLEAR) begin
      foreach (key_tally[i]) key_tally[i] = '0;
      lead_key   = '0;
      lead_count = '0;
    end else begin
      cnt = key_tally[req.event_key];
      if (cnt != COUNT_MAX) cnt = cnt + 1'b1;   // saturate, never wrap
      key_tally[req.event_key] = cnt;
      // strictly greater only: on a tie the earlier key keeps the lead
      if (cnt > lead_count) begin
        lead_count = cnt;
        lead_key   = req.event_key;
      end
    end
    leader.leader_key   = lead_key;
    leader.leader_count = lead_count;
    return leader;
  endfunction

  // ---------------------------------------------------------------------------
  // Queues: transactions still to send, and leaders still owed by the block.
  // ---------------------------------------------------------------------------
  smt_req_t event_backlog [$];
  smt_res_t leader_due    [$];
  int       send_idle_pct = 21;

  int mismatches = 0;
  int cycles     = 0;

  // Driver. A transaction goes through on an edge with start high and busy low;
  // its leader is predicted right there, so the queue stays in acceptance order.
  // start and request get one assignment per edge at most.
  always @(posedge clk) begin
    if (rst) begin
      start   <= 1'b0;
      request <= '0;
    end else begin
      if (start && !busy) leader_due = {leader_due, tally_event(request)};
      if (!start || !busy) begin
        if (event_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          start   <= 1'b1;
          request <= event_backlog.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor. done is a one-cycle strobe; the result is taken at the edge ending it.
  smt_res_t owed;

  task automatic flag_mismatch(string what, int unsigned want, int unsigned got);
    mismatches++;
    if (mismatches <= REPORT_FIRST)
      $display("[%0t] MISMATCH %s: expected %0d, got %0d", $realtime, what, want, got);
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (leader_due.size() == 0) begin
        flag_mismatch("unexpected result, key", 0, result.leader_key);
      end else begin
        owed = leader_due.pop_front();
        if (result.leader_key !== owed.leader_key)
          flag_mismatch("leader_key", owed.leader_key, result.leader_key);
        if (result.leader_count !== owed.leader_count)
          flag_mismatch("leader_count", owed.leader_count, result.leader_count);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("streaming_mode_tracker verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic queue_event(logic op, logic [KEY_BITS-1:0] key);
    smt_req_t req;
    req.operation = op;
    req.event_key = key;
    event_backlog = {event_backlog, req};
  endtask

  // Waits until the backlog is empty, start is low and every leader is back.
  task automatic wait_drained();
    while (event_backlog.size() != 0 || start || leader_due.size() != 0)
      @(negedge clk);
  endtask

  // Random traffic. Mostly a small set of hot keys so that counts climb, ties
  // form and the lead changes hands; some back-to-back repeats to hit the
  // write-stage forwarding; a sprinkle of uniform keys and clears.
  task automatic queue_random(int n);
    logic [KEY_BITS-1:0] hot [8];
    logic [KEY_BITS-1:0] prev;
    int                  roll;
    prev = '0;
    foreach (hot[i]) hot[i] = KEY_BITS'($urandom);
    for (int k = 0; k < n; k++) begin
      roll = $urandom_range(99);
      if (roll < 3) begin
        // key field is don't-care on a clear; drive it randomly anyway
        queue_event(OP_CLEAR, KEY_BITS'($urandom));
        foreach (hot[i]) hot[i] = KEY_BITS'($urandom);
      end else begin
        if (roll < 15)      prev = prev;
        else if (roll < 85) prev = hot[3'($urandom_range(7))];
        else                prev = KEY_BITS'($urandom);
        queue_event(OP_COUNT, prev);
        if ($urandom_range(59) == 0) hot[3'($urandom_range(7))] = KEY_BITS'($urandom);
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Phase 1: sender idles about a fifth of the time.
    // Directed opening: empty set, extreme keys, ties, clears.
    queue_event(OP_CLEAR, '0);           // clear on an empty store
    queue_event(OP_COUNT, '0);           // key 0 leads with 1
    queue_event(OP_COUNT, '1);           // tie at 1, key 0 keeps the lead
    queue_event(OP_COUNT, '1);           // key 1023 overtakes with 2
    queue_event(OP_COUNT, '0);           // tie at 2, no change
    queue_event(OP_COUNT, '0);           // key 0 back in front with 3
    queue_event(OP_COUNT, 10'h2AA);
    queue_event(OP_COUNT, 10'h155);
    queue_event(OP_COUNT, 10'h155);
    queue_event(OP_COUNT, 10'h155);      // tie at 3
    queue_event(OP_COUNT, 10'h155);      // 4 takes the lead
    queue_event(OP_CLEAR, '1);           // key field ignored on clear
    queue_event(OP_CLEAR, 10'h2AA);      // clear straight after clear
    queue_event(OP_COUNT, 10'h155);      // old count must be gone
    queue_event(OP_COUNT, 10'h2AA);
    queue_event(OP_COUNT, 10'h2AA);
    queue_event(OP_CLEAR, 10'h155);
    queue_event(OP_COUNT, '1);
    queue_random(300);
    wait_drained();

    // Phase 2: sender mostly idle.
    send_idle_pct = 61;
    queue_random(300);
    wait_drained();

    // Phase 3: full rate. Back-to-back runs on one key through the forwarding
    // path, a second key that ties it and must not take the lead, then one more
    // hit that does.
    send_idle_pct = 0;
    queue_event(OP_CLEAR, '0);
    repeat (HOT_RUN) queue_event(OP_COUNT, 10'h3A5);
    repeat (HOT_RUN) queue_event(OP_COUNT, 10'h05A);
    queue_event(OP_COUNT, 10'h05A);
    queue_random(150);
    wait_drained();

    repeat (16) @(posedge clk);
    if (mismatches == 0 && leader_due.size() == 0) begin
      $display("streaming_mode_tracker verification clean");
    end else begin
      $display("streaming_mode_tracker verification failed");
    end
    $finish;
  end

endmodule
